[rtl/rsm_pkg.sv]
// ----------------------------------------------------------------------------
// rsm_pkg: shared definitions for the running sum, mean and extremes unit
// Sizes of the result fields and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsm_pkg;

    localparam int unsigned DEF_MAX_ITEMS     = 1024;
    localparam int unsigned DEF_FRACTION_BITS = 8;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned OUT_SUM_W = 42;
    localparam int unsigned OUT_MEAN_W = 40;
    localparam int unsigned OUT_CNT_W = 11;

    localparam int unsigned RES_BITS  = OUT_SUM_W + OUT_MEAN_W + 4 * VALUE_W + OUT_CNT_W;
    localparam int unsigned RES_DATA_W = ((RES_BITS + 7) / 8) * 8;
    localparam int unsigned RES_USER_W = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

[rtl/running_sum_mean_top_two_extremes_unit.sv]
// ----------------------------------------------------------------------------
// Sequence: an ordinary item is taken as it is offered; after the last item of a
// run the sequencer goes through ST_LOAD, ST_DIV and ST_DONE, and the result is
// registered on the output from ST_DONE. The mean is formed by the one-bit-per-cycle
// restoring divider over DIV_W = 32 + clog2(MAX_ITEMS) + FRACTION_BITS bits.
// Throughput: 1 item per cycle inside a run; not ready while the mean is formed
// or while the finished result waits for the previous one to leave the output.
// Reset: asynchronous, active low; clears the run state and the result valid.
// ----------------------------------------------------------------------------
// running_sum_mean_top_two_extremes_unit
// Running sum, count, top two and bottom two of a run, with fixed-point mean.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_sum_mean_top_two_extremes_unit #(
    parameter int unsigned MAX_ITEMS     = rsm_pkg::DEF_MAX_ITEMS,
    parameter int unsigned FRACTION_BITS = rsm_pkg::DEF_FRACTION_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rsm_pkg::VALUE_W-1:0]       s_axis_tdata,   // value
    input  logic                              s_axis_tlast,   // is_last
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // total_sum, mean_fixed, largest, second_largest, smallest,
    // second_smallest, item_count, zero pad
    output logic [rsm_pkg::RES_DATA_W-1:0]    m_axis_tdata,
    output logic [rsm_pkg::RES_USER_W-1:0]    m_axis_tuser    // second_valid, count_overflow
);

    import rsm_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int unsigned SUM_W  = VALUE_W + $clog2(MAX_ITEMS);
    localparam int unsigned DIV_W  = SUM_W + FRACTION_BITS;
    localparam int unsigned STEP_W = $clog2(DIV_W);
    localparam int unsigned WIDE_W = DIV_W + OUT_MEAN_W;

    state_t state_reg, state_next;

    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [VALUE_W-1:0] top1_reg, top1_next, top2_reg, top2_next;
    logic signed [VALUE_W-1:0] bot1_reg, bot1_next, bot2_reg, bot2_next;
    logic                      drop_reg, drop_next;

    logic [DIV_W-1:0]          quo_reg, quo_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic [STEP_W-1:0]         step_reg, step_next;

    logic                      out_valid_reg, out_valid_next;
    logic [RES_DATA_W-1:0]     out_data_reg;
    logic [RES_USER_W-1:0]     out_user_reg;

    logic                      in_fire;
    logic                      take_value;
    logic                      load_result;
    logic signed [VALUE_W-1:0] v;

    logic [SUM_W-1:0]          sum_mag;
    logic [CNT_W:0]            rem_shift;
    logic [CNT_W+1:0]          trial;

    logic [OUT_SUM_W+SUM_W-1:0]   sum_wide;
    logic [WIDE_W-1:0]            quo_wide;
    logic [WIDE_W-1:0]            mean_wide;
    logic [OUT_CNT_W+CNT_W-1:0]   cnt_wide;
    logic                         sv;
    logic [RES_BITS-1:0]          res_bits;
    logic [RES_DATA_W-1:0]        res_data;

    assign v           = s_axis_tdata;
    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign take_value  = in_fire && (count_reg < CNT_W'(MAX_ITEMS));
    assign load_result = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire && s_axis_tlast) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (step_reg == '0) state_next = ST_DONE;
            ST_DONE: if (load_result) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            default: s_axis_tready = 1'b0;
        endcase
    end

    // run state update
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        top1_next  = top1_reg;
        top2_next  = top2_reg;
        bot1_next  = bot1_reg;
        bot2_next  = bot2_reg;
        drop_next  = drop_reg;
        if (load_result)
        begin
            sum_next   = '0;
            count_next = '0;
            top1_next  = '0;
            top2_next  = '0;
            bot1_next  = '0;
            bot2_next  = '0;
            drop_next  = 1'b0;
        end
        else if (take_value)
        begin
            if (count_reg == '0)
            begin
                top1_next = v;
                bot1_next = v;
            end
            else
            begin
                if (v > top1_reg)
                begin
                    top2_next = top1_reg;
                    top1_next = v;
                end
                else if (count_reg == CNT_W'(1) || v > top2_reg)
                    top2_next = v;
                if (v < bot1_reg)
                begin
                    bot2_next = bot1_reg;
                    bot1_next = v;
                end
                else if (count_reg == CNT_W'(1) || v < bot2_reg)
                    bot2_next = v;
            end
            sum_next   = sum_reg + SUM_W'(v);
            count_next = count_reg + CNT_W'(1);
        end
        else if (in_fire)
            drop_next = 1'b1;
    end

    // restoring divider, one quotient bit a cycle
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, count_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        case (state_reg)
            ST_LOAD:
            begin
                quo_next  = DIV_W'(sum_mag) << FRACTION_BITS;
                rem_next  = '0;
                step_next = STEP_W'(DIV_W - 1);
            end
            ST_DIV:
            begin
                if (!trial[CNT_W+1])
                begin
                    rem_next = trial[CNT_W-1:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[CNT_W-1:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b0};
                end
                step_next = step_reg - STEP_W'(1);
            end
            default: ;
        endcase
    end

    // result assembly
    assign sv        = count_reg >= CNT_W'(2);
    assign sum_wide  = {{OUT_SUM_W{sum_reg[SUM_W-1]}}, sum_reg};
    assign quo_wide  = (count_reg == '0) ? '0 : {{OUT_MEAN_W{1'b0}}, quo_reg};
    assign mean_wide = sum_reg[SUM_W-1] ? (~quo_wide + WIDE_W'(1)) : quo_wide;
    assign cnt_wide  = {{OUT_CNT_W{1'b0}}, count_reg};
    assign res_bits  = {cnt_wide[OUT_CNT_W-1:0],
                        sv ? bot2_reg : '0,
                        bot1_reg,
                        sv ? top2_reg : '0,
                        top1_reg,
                        mean_wide[OUT_MEAN_W-1:0],
                        sum_wide[OUT_SUM_W-1:0]};
    assign res_data  = RES_DATA_W'(res_bits);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_result)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            top1_reg      <= '0;
            top2_reg      <= '0;
            bot1_reg      <= '0;
            bot2_reg      <= '0;
            drop_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            top1_reg      <= top1_next;
            top2_reg      <= top2_next;
            bot1_reg      <= bot1_next;
            bot2_reg      <= bot2_next;
            drop_reg      <= drop_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (load_result)
        begin
            out_data_reg <= res_data;
            out_user_reg <= {drop_reg, sv};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // checks
    a_last_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=> (state_reg == ST_LOAD))
        else $error("last item did not start the mean");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=> (count_reg != '0))
        else $error("run ended with no item counted");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done step");

endmodule

[tb/running_sum_mean_top_two_extremes_unit_tb.sv]
// ----------------------------------------------------------------------------
// running_sum_mean_top_two_extremes_unit_tb: self-checking bench for the run unit
// Streams runs of signed values, predicts the sum, mean, count and the top two
// and bottom two of each run, and checks every summary item in order. Runs go
// through phases of input gaps and output back-pressure, plus a capacity run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module running_sum_mean_top_two_extremes_unit_tb;

    import rsm_pkg::*;

    localparam int unsigned MAX_ITEMS  = DEF_MAX_ITEMS;
    localparam int unsigned FRAC_BITS  = DEF_FRACTION_BITS;
    localparam int unsigned MEAN_LSB   = OUT_SUM_W;
    localparam int unsigned LARGE1_LSB = MEAN_LSB + OUT_MEAN_W;
    localparam int unsigned LARGE2_LSB = LARGE1_LSB + VALUE_W;
    localparam int unsigned SMALL1_LSB = LARGE2_LSB + VALUE_W;
    localparam int unsigned SMALL2_LSB = SMALL1_LSB + VALUE_W;
    localparam int unsigned COUNT_LSB  = SMALL2_LSB + VALUE_W;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned PHASE_ITEMS = 240;

    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;

    typedef struct {
        logic [OUT_SUM_W-1:0]  total_sum;
        logic [OUT_MEAN_W-1:0] mean_fixed;
        logic [VALUE_W-1:0]    largest;
        logic [VALUE_W-1:0]    second_largest;
        logic [VALUE_W-1:0]    smallest;
        logic [VALUE_W-1:0]    second_smallest;
        logic [OUT_CNT_W-1:0]  item_count;
        logic                  second_valid;
        logic                  count_overflow;
    } run_summary_t;

    class run_summary_scoreboard;
        logic signed [OUT_SUM_W-1:0] total;
        int unsigned                 count;
        logic signed [VALUE_W-1:0]   top1;
        logic signed [VALUE_W-1:0]   top2;
        logic signed [VALUE_W-1:0]   bot1;
        logic signed [VALUE_W-1:0]   bot2;
        logic                        dropped;
        run_summary_t                pending_summaries[$];
        int unsigned                 errors;

        function new();
            errors = 0;
            clear_run();
        endfunction

        function void clear_run();
            total   = '0;
            count   = 0;
            top1    = '0;
            top2    = '0;
            bot1    = '0;
            bot2    = '0;
            dropped = 1'b0;
        endfunction

        function void take_value(logic signed [VALUE_W-1:0] v, logic last);
            run_summary_t s;
            longint       sum64;
            longint       mag;
            longint       quot;
            logic         two;
            if (count < MAX_ITEMS)
            begin
                if (count == 0)
                begin
                    top1 = v;
                    bot1 = v;
                end
                else
                begin
                    if (v > top1)
                    begin
                        top2 = top1;
                        top1 = v;
                    end
                    else if (count == 1 || v > top2)
                        top2 = v;
                    if (v < bot1)
                    begin
                        bot2 = bot1;
                        bot1 = v;
                    end
                    else if (count == 1 || v < bot2)
                        bot2 = v;
                end
                total = total + v;
                count++;
            end
            else
                dropped = 1'b1;
            if (!last)
                return;
            two   = (count >= 2);
            sum64 = total;
            mag   = (sum64 < 0) ? -sum64 : sum64;
            quot  = (count == 0) ? 0 : (mag << FRAC_BITS) / longint'(count);
            if (sum64 < 0)
                quot = -quot;
            s.total_sum       = total;
            s.mean_fixed      = quot[OUT_MEAN_W-1:0];
            s.largest         = top1;
            s.second_largest  = two ? top2 : '0;
            s.smallest        = bot1;
            s.second_smallest = two ? bot2 : '0;
            s.item_count      = count[OUT_CNT_W-1:0];
            s.second_valid    = two;
            s.count_overflow  = dropped;
            pending_summaries.push_back(s);
            clear_run();
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_summary(logic [RES_DATA_W-1:0] data, logic [RES_USER_W-1:0] user);
            run_summary_t s;
            if (pending_summaries.size() == 0)
            begin
                $display("%0t: unexpected summary item: expected none, got %h / %b",
                         $time, data, user);
                errors++;
                return;
            end
            s = pending_summaries.pop_front();
            compare("total_sum", 64'(s.total_sum), 64'(data[MEAN_LSB-1:0]));
            compare("mean_fixed", 64'(s.mean_fixed), 64'(data[LARGE1_LSB-1:MEAN_LSB]));
            compare("largest", 64'(s.largest), 64'(data[LARGE2_LSB-1:LARGE1_LSB]));
            compare("second_largest", 64'(s.second_largest),
                    64'(data[SMALL1_LSB-1:LARGE2_LSB]));
            compare("smallest", 64'(s.smallest), 64'(data[SMALL2_LSB-1:SMALL1_LSB]));
            compare("second_smallest", 64'(s.second_smallest),
                    64'(data[COUNT_LSB-1:SMALL2_LSB]));
            compare("item_count", 64'(s.item_count),
                    64'(data[COUNT_LSB+OUT_CNT_W-1:COUNT_LSB]));
            compare("second_valid", 64'(s.second_valid), 64'(user[0]));
            compare("count_overflow", 64'(s.count_overflow), 64'(user[1]));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [VALUE_W-1:0]    s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [RES_DATA_W-1:0] m_axis_tdata;
    logic [RES_USER_W-1:0] m_axis_tuser;

    run_summary_scoreboard sb;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned phase_items;

    running_sum_mean_top_two_extremes_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            sb.take_value(s_axis_tdata, s_axis_tlast);
        if (m_axis_tvalid && m_axis_tready)
            sb.check_summary(m_axis_tdata, m_axis_tuser);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d summaries outstanding",
                     $time, sb.pending_summaries.size());
            $display("running_sum_mean_top_two_extremes_unit_tb: errors");
            $finish;
        end
    end

    task automatic send_item(logic [VALUE_W-1:0] v, logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        phase_items++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_summaries.size() != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(logic [VALUE_W-1:0] prev);
        case ($urandom_range(9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return prev;
            3, 4:    return VALUE_W'(int'($urandom_range(40)) - 20);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random_run(int unsigned len);
        logic [VALUE_W-1:0] v;
        v = $urandom();
        for (int unsigned i = 0; i < len; i++)
        begin
            v = pick_value(v);
            send_item(v, i == len - 1);
        end
    endtask

    task automatic send_fill_run(logic [VALUE_W-1:0] v, int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_item(v, i == len - 1);
    endtask

    initial
    begin
        int unsigned len;
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-item runs: seconds invalid
        send_item(VAL_MAX, 1'b1);
        send_item(VAL_MIN, 1'b1);
        send_item('0, 1'b1);
        // equal pair fills both first and second
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b1);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b1);
        send_item(VAL_MAX, 1'b0);
        send_item('0, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b1);
        // truncation of the mean toward zero, both signs
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item('0, 1'b0);
        send_item('0, 1'b1);
        send_item(32'd1, 1'b0);
        send_item('0, 1'b0);
        send_item('0, 1'b1);
        send_item(32'd3, 1'b0);
        send_item(32'd1, 1'b0);
        send_item(32'd2, 1'b0);
        send_item(32'd1, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            endcase
            if (ph == 2)
                hold_request = 400;
            if (ph == 0)
            begin
                // capacity reached, then overflow with the last two items dropped
                send_fill_run(VAL_MIN, MAX_ITEMS + 2);
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                case ($urandom_range(19))
                    0:       len = $urandom_range(120, 41);
                    1, 2, 3,
                    4, 5:    len = $urandom_range(40, 9);
                    default: len = $urandom_range(8, 1);
                endcase
                send_random_run(len);
            end
        end

        wait_drained();
        repeat (3 + 32 + 11 + FRAC_BITS + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("running_sum_mean_top_two_extremes_unit_tb: clean");
        else
            $display("running_sum_mean_top_two_extremes_unit_tb: errors");
        $finish;
    end

endmodule

[files.f]
rtl/rsm_pkg.sv
rtl/running_sum_mean_top_two_extremes_unit.sv
tb/running_sum_mean_top_two_extremes_unit_tb.sv
